/* rtl/core/salc_pkg.sv */
// shared types, codes and helpers for the set-associative lru cache model
// no dependencies; imported by salc_split, salc_scan and the top level

package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 4;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 48;

  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int SETB_W     = 3;
  localparam int BLKB_W     = 5;
  localparam int WAYSU_W    = 4;
  localparam int AGE_W      = 32;
  localparam int TOT_W      = 32;
  localparam int WAY_MAX_W  = 4;

  typedef enum logic [1:0] {
    FUNC_INSTR  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_STORE  = 2'd2,
    FUNC_MODIFY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_FILL  = 2'd2,
    OUT_EVICT = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                 hit;
    logic                 have_empty;
    logic [WAY_MAX_W-1:0] hit_way;
    logic [WAY_MAX_W-1:0] empty_way;
    logic [WAY_MAX_W-1:0] victim_way;
  } scan_res_t;

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/core/salc_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/salc_split.sv */
// address splitter: tag and set base line from the configured field sizes
// depends on salc_pkg

module salc_split #(
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int LINE_W       = 7
) (
  input  logic [ADDR_WIDTH-1:0]          addr,
  input  logic [salc_pkg::SETB_W-1:0]    set_width,
  input  logic [salc_pkg::BLKB_W-1:0]    offset_width,
  output logic [ADDR_WIDTH-1:0]          tag,
  output logic [LINE_W-1:0]              base
);

  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [3:0]            s_eff;
  logic [5:0]            shamt;
  logic [ADDR_WIDTH-1:0] off_sh;
  logic [SET_W:0]        one_sh;
  logic [SET_W:0]        idx_mask;
  logic [SET_W-1:0]      set_idx;

  always_comb begin
    s_eff    = ({1'b0, set_width} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_width};
    shamt    = 6'(s_eff) + 6'(offset_width);
    tag      = addr >> shamt;
    off_sh   = addr >> offset_width;
    one_sh   = (SET_W + 1)'(1) << s_eff;
    idx_mask = one_sh - 1'b1;
    set_idx  = off_sh[SET_W-1:0] & idx_mask[SET_W-1:0];
    base     = LINE_W'(LINE_W'(set_idx) * LINE_W'(MAX_WAYS));
  end

endmodule

/* rtl/core/salc_scan.sv */
// way scan unit: tag compare, last empty way and oldest way tracking
// depends on salc_pkg

module salc_scan #(
  parameter int TAG_W = salc_pkg::ADDR_WIDTH_DEF,
  parameter int WAY_W = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        step,
  input  logic [WAY_W-1:0]            way,
  input  logic                        line_v,
  input  logic [TAG_W-1:0]            line_tag,
  input  logic [salc_pkg::AGE_W-1:0]  line_age,
  input  logic [TAG_W-1:0]            target_tag,
  output salc_pkg::scan_res_t         res
);

  import salc_pkg::*;

  logic             hit_r;
  logic             empty_r;
  logic [WAY_W-1:0] hit_way_r;
  logic [WAY_W-1:0] empty_way_r;
  logic [WAY_W-1:0] victim_r;
  logic [AGE_W-1:0] best_r;
  logic [AGE_W-1:0] age_eff;

  assign age_eff = line_v ? line_age : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (clr) begin
      hit_r    <= 1'b0;
      empty_r  <= 1'b0;
      best_r   <= '0;
      victim_r <= '0;
    end else if (step) begin
      if (line_v && !hit_r && (line_tag == target_tag)) begin
        hit_r     <= 1'b1;
        hit_way_r <= way;
      end
      if (!line_v) begin
        empty_r     <= 1'b1;
        empty_way_r <= way;
      end
      if (age_eff > best_r) begin
        best_r   <= age_eff;
        victim_r <= way;
      end
    end
  end

  always_comb begin
    res.hit        = hit_r;
    res.have_empty = empty_r;
    res.hit_way    = WAY_MAX_W'(hit_way_r);
    res.empty_way  = WAY_MAX_W'(empty_way_r);
    res.victim_way = WAY_MAX_W'(victim_r);
  end

endmodule

/* rtl/core/set_assoc_lru_cache_sim.sv */
// top level of the tag-only set-associative cache with age lru replacement
// depends on salc_pkg, salc_ram, salc_split, salc_scan
//
// A request is taken when start is high and busy is low. The ways of the addressed set are
// walked one per cycle through a single tag/age ram port, first to search, then to age and
// write back. A modify searches and updates the set twice; an instruction fetch skips the walk.
// The result is shown for one cycle with out_valid; the receiver cannot stall it, and busy is
// already low in that cycle so the next request can be taken. Valid bits are cleared at reset,
// so no clearing pass is needed.

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [ADDR_WIDTH-1:0]          in_address,
  output logic                           out_valid,
  output logic [1:0]                     out_first_outcome,
  output logic [1:0]                     out_second_outcome,
  output logic [salc_pkg::TOT_W-1:0]     out_hit_total,
  output logic [salc_pkg::TOT_W-1:0]     out_miss_total,
  output logic [salc_pkg::TOT_W-1:0]     out_eviction_total,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]     cfg_wdata
);

  import salc_pkg::*;

  localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CNT_W     = $clog2(MAX_WAYS + 1);
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WORD_W    = ADDR_WIDTH + AGE_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_UPD    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SETB_W-1:0]     set_width_r;
  logic [BLKB_W-1:0]     offset_width_r;
  logic [WAYSU_W-1:0]    ways_in_use_r;

  func_t                 func_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [LINE_W-1:0]     base_r;
  logic [CNT_W-1:0]      ways_r;
  logic [CNT_W-1:0]      rd_cnt_r;
  logic                  p_vld_r;
  logic [WAY_W-1:0]      p_way_r;
  logic [LINE_W-1:0]     p_addr_r;
  logic                  p_lv_r;
  logic                  second_r;
  logic [WAY_W-1:0]      touched_r;
  outcome_t              first_r;
  outcome_t              second_out_r;
  logic [TOT_W-1:0]      hit_cnt_r;
  logic [TOT_W-1:0]      miss_cnt_r;
  logic [TOT_W-1:0]      evict_cnt_r;
  logic                  out_valid_r;
  logic                  valid_r [NUM_LINES];

  logic [ADDR_WIDTH-1:0] split_tag;
  logic [LINE_W-1:0]     split_base;
  logic [4:0]            ways_eff;
  logic [LINE_W-1:0]     raddr;
  logic                  walking;
  logic                  issue;
  logic                  walk_end;
  logic                  scan_clr;
  logic                  scan_step;
  logic                  ram_we;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [ADDR_WIDTH-1:0] rd_tag;
  logic [AGE_W-1:0]      rd_age;
  logic                  is_touched;
  logic                  again;
  outcome_t              outc;
  logic [WAY_W-1:0]      pick_way;
  scan_res_t             sr;

  salc_split #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .LINE_W      (LINE_W)
  ) u_split (
    .addr        (addr_r),
    .set_width   (set_width_r),
    .offset_width(offset_width_r),
    .tag         (split_tag),
    .base        (split_base)
  );

  salc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_LINES),
    .AW   (LINE_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(p_addr_r),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  salc_scan #(
    .TAG_W(ADDR_WIDTH),
    .WAY_W(WAY_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .step      (scan_step),
    .way       (p_way_r),
    .line_v    (p_lv_r),
    .line_tag  (rd_tag),
    .line_age  (rd_age),
    .target_tag(tag_r),
    .res       (sr)
  );

  always_comb begin
    rd_tag     = ram_rdata[AGE_W +: ADDR_WIDTH];
    rd_age     = ram_rdata[AGE_W-1:0];
    raddr      = base_r + LINE_W'(rd_cnt_r);
    walking    = (state_r == S_SCAN) || (state_r == S_UPD);
    issue      = walking && (rd_cnt_r < ways_r);
    walk_end   = walking && p_vld_r && (rd_cnt_r == ways_r);
    again      = (func_r == FUNC_MODIFY) && !second_r;
    scan_clr   = (state_r == S_PREP) || ((state_r == S_UPD) && walk_end && again);
    scan_step  = (state_r == S_SCAN) && p_vld_r;
    is_touched = (p_way_r == touched_r);
    ram_we     = (state_r == S_UPD) && p_vld_r && (is_touched || p_lv_r);
    ram_wdata  = is_touched ? {tag_r, {AGE_W{1'b0}}} : {rd_tag, sat_inc(rd_age)};

    if (ways_in_use_r == '0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_in_use_r} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_in_use_r};
    end

    if (sr.hit) begin
      outc     = OUT_HIT;
      pick_way = sr.hit_way[WAY_W-1:0];
    end else if (sr.have_empty) begin
      outc     = OUT_FILL;
      pick_way = sr.empty_way[WAY_W-1:0];
    end else begin
      outc     = OUT_EVICT;
      pick_way = sr.victim_way[WAY_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (func_t'(in_func) == FUNC_INSTR) ? S_DONE : S_PREP;
        end
      end
      S_PREP:   state_nxt = S_SCAN;
      S_SCAN:   if (walk_end) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_UPD;
      S_UPD:    if (walk_end) state_nxt = again ? S_SCAN : S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      set_width_r    <= SETB_W'(3);
      offset_width_r <= BLKB_W'(2);
      ways_in_use_r  <= WAYSU_W'(1);
      hit_cnt_r      <= '0;
      miss_cnt_r     <= '0;
      evict_cnt_r    <= '0;
      out_valid_r    <= 1'b0;
      p_vld_r        <= 1'b0;
      second_r       <= 1'b0;
      rd_cnt_r       <= '0;
      first_r        <= OUT_NONE;
      second_out_r   <= OUT_NONE;
      for (int i = 0; i < NUM_LINES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_width_r    <= cfg_wdata[SETB_W-1:0];
          CFG_BLOCK_BITS: offset_width_r <= cfg_wdata[BLKB_W-1:0];
          CFG_WAYS:       ways_in_use_r  <= cfg_wdata[WAYSU_W-1:0];
          default: ;
        endcase
      end

      p_vld_r <= issue;
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
        p_way_r  <= rd_cnt_r[WAY_W-1:0];
        p_addr_r <= raddr;
        p_lv_r   <= valid_r[raddr];
      end

      if (ram_we && is_touched) begin
        valid_r[p_addr_r] <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r       <= func_t'(in_func);
            addr_r       <= in_address;
            first_r      <= OUT_NONE;
            second_out_r <= OUT_NONE;
            second_r     <= 1'b0;
          end
        end
        S_PREP: begin
          tag_r    <= split_tag;
          base_r   <= split_base;
          ways_r   <= CNT_W'(ways_eff);
          rd_cnt_r <= '0;
        end
        S_DECIDE: begin
          touched_r <= pick_way;
          rd_cnt_r  <= '0;
          if (second_r) begin
            second_out_r <= outc;
          end else begin
            first_r <= outc;
          end
          if (outc == OUT_HIT) begin
            hit_cnt_r <= sat_inc(hit_cnt_r);
          end else begin
            miss_cnt_r <= sat_inc(miss_cnt_r);
          end
          if (outc == OUT_EVICT) begin
            evict_cnt_r <= sat_inc(evict_cnt_r);
          end
        end
        S_UPD: begin
          if (walk_end && again) begin
            second_r <= 1'b1;
            rd_cnt_r <= '0;
          end
        end
        S_SCAN, S_DONE: ;
        default: ;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_first_outcome  = first_r;
  assign out_second_outcome = second_out_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_second_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_second_outcome != OUT_NONE)) |->
      ((out_second_outcome == OUT_HIT) && (out_first_outcome != OUT_NONE)))
    else $error("second access of a modify did not hit");

  a_evict_full_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_first_outcome == OUT_EVICT)) |-> (out_eviction_total != '0))
    else $error("eviction reported without eviction count");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (hit_cnt_r >= $past(hit_cnt_r)))
    else $error("hit count decreased");

endmodule
